[hdl/bbs_pkg.sv]
// Shared constants for the Blum Blum Shub keystream cipher.
package bbs_pkg;

	localparam int MOD_BITS_DEF = 32;
	localparam int CFG_W        = 32;
	localparam int BYTE_W       = 8;
	localparam int SQUARINGS    = 8;
	localparam int SQ_W         = $clog2(SQUARINGS);
	localparam int IDX_W        = 1;

	localparam logic [IDX_W-1:0] REG_MODULUS = 1'd0;
	localparam logic [IDX_W-1:0] REG_SEED    = 1'd1;

endpackage

[hdl/bbs_keystream_xor_cipher.sv]
// Blum Blum Shub keystream cipher with a bit-serial interleaved modular multiplier.
// Sequence: each squaring is a load step plus a multiply pass, and a byte takes eight squarings;
// a reduction pass comes first after a seed load or a modulus write.
// A new byte is accepted only in idle, once the previous result is posted; the multiply and
// reduce passes share one multiply-reduce step that handles one multiplier bit per cycle.
// Reset: async active low; generator value 0, modulus 1, seed 0, no output pending.
module bbs_keystream_xor_cipher
	import bbs_pkg::*;
#(
	parameter int MOD_BITS = MOD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
	input  logic              s_tuser,   // [0] message_start
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
	input  logic              cfg_wr_en,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int W     = MOD_BITS;
	localparam int CNT_W = $clog2(W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);
	localparam logic [SQ_W-1:0]  SQ_LAST  = SQ_W'(SQUARINGS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]        state_q;
	logic [W-1:0]      mod_q;
	logic [W-1:0]      seed_q;
	logic [W-1:0]      x_q;
	logic [W-1:0]      acc_q;
	logic [W-1:0]      k_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SQ_W-1:0]   sq_q;
	logic [BYTE_W-1:0] key_q;
	logic [BYTE_W-1:0] data_q;
	logic [BYTE_W-1:0] out_q;
	logic              out_vld_q;
	logic              red_ok_q;

	logic [W-1:0]      cfg_val;
	logic [W+1:0]      addend;
	logic [W+1:0]      t_sum;
	logic [W+1:0]      d1;
	logic [W+1:0]      d2;
	logic [W-1:0]      nacc;
	logic              accept;
	logic              out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;
	assign out_free = !out_vld_q || m_tready;
	assign cfg_val  = W'(cfg_data);

	// reduce pass feeds raw bits; multiply pass feeds x when the multiplier bit is set
	always_comb begin
		if (state_q == ST_RED) begin
			addend = {{(W+1){1'b0}}, k_q[W-1]};
		end else if (k_q[W-1]) begin
			addend = {2'b00, x_q};
		end else begin
			addend = '0;
		end
		t_sum = {1'b0, acc_q, 1'b0} + addend;
		d1    = t_sum - {2'b00, mod_q};
		d2    = t_sum - {1'b0, mod_q, 1'b0};
		if (!d2[W+1]) begin
			nacc = d2[W-1:0];
		end else if (!d1[W+1]) begin
			nacc = d1[W-1:0];
		end else begin
			nacc = t_sum[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mod_q     <= W'(1);
			seed_q    <= '0;
			x_q       <= '0;
			cnt_q     <= '0;
			sq_q      <= '0;
			out_vld_q <= 1'b0;
			red_ok_q  <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						data_q <= s_tdata;
						sq_q   <= '0;
						cnt_q  <= '0;
						acc_q  <= '0;
						if (s_tuser) begin
							x_q     <= seed_q;
							k_q     <= seed_q;
							state_q <= ST_RED;
						end else if (!red_ok_q) begin
							k_q     <= x_q;
							state_q <= ST_RED;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_RED: begin
					acc_q <= nacc;
					k_q   <= {k_q[W-2:0], 1'b0};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						x_q     <= nacc;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					k_q     <= x_q;
					acc_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					acc_q <= nacc;
					k_q   <= {k_q[W-2:0], 1'b0};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						x_q   <= nacc;
						key_q <= {key_q[BYTE_W-2:0], nacc[0]};
						sq_q  <= sq_q + SQ_W'(1);
						if (sq_q == SQ_LAST) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_q   <= data_q ^ key_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if ((state_q == ST_FIN) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (cfg_wr_en && (cfg_index == REG_MODULUS)) begin
				red_ok_q <= 1'b0;
			end else if ((state_q == ST_RED) && (cnt_q == CNT_LAST)) begin
				red_ok_q <= 1'b1;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MODULUS: begin
						mod_q <= (cfg_val == '0) ? W'(1) : cfg_val;
					end
					REG_SEED: begin
						seed_q <= cfg_val;
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_x_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (x_q < mod_q))
		else $error("multiplicand not reduced");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MUL) || (state_q == ST_RED)) |-> (acc_q < mod_q))
		else $error("accumulator out of range");

	a_last_sq: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MUL) && (cnt_q == CNT_LAST) && (sq_q == SQ_LAST))
		|=> (state_q == ST_FIN))
		else $error("missed end of byte");

	a_out_set: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && out_free) |=> (out_vld_q && (state_q == ST_IDLE)))
		else $error("result not posted");

endmodule

[sim/tb_top.sv]
// Testbench for bbs_keystream_xor_cipher: directed table plus random messages, checked by predictor.
module tb_top;
	import bbs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS       = 950;
	localparam int IDLE_PCT    = 10;
	localparam int SETTLE      = 48;
	localparam int DRAIN       = 300;
	localparam int HOLD_CYCLES = 3000;
	localparam int HOLD_AFTER  = 300;
	localparam int LIMIT       = 2000000;
	localparam int N_ROWS      = 24;

	typedef enum logic {ROW_REGS, ROW_WORD} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [CFG_W-1:0]  modulus;
		logic [CFG_W-1:0]  seed;
		logic [BYTE_W-1:0] data;
		logic              start;
		logic              pinned;
		logic [BYTE_W-1:0] pinned_out;
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata;   // [7:0] data_byte
	logic              s_tuser;   // [0] message_start
	logic              m_tvalid;
	logic              m_tready;
	logic [BYTE_W-1:0] m_tdata;   // [7:0] out_byte
	logic              cfg_wr_en;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	logic              pin_en;
	logic [BYTE_W-1:0] pin_byte;

	logic [CFG_W-1:0]  bbs_modulus = 1;
	logic [CFG_W-1:0]  bbs_seed    = 0;
	logic [CFG_W-1:0]  bbs_x       = 0;

	logic [BYTE_W-1:0] out_byte_q[$];
	int unsigned       errors       = 0;
	int unsigned       results_seen = 0;
	bit                calm         = 0;

	row_t dir_rows [N_ROWS];

	bbs_keystream_xor_cipher u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// eight squarings per byte, low bit of each shifted in from the right
	function automatic logic [BYTE_W-1:0] next_keystream(input logic start);
		logic [63:0]       m;
		logic [63:0]       x;
		logic [BYTE_W-1:0] ks;
		m = (bbs_modulus == '0) ? 64'd1 : {32'd0, bbs_modulus};
		if (start)
			bbs_x = bbs_seed;
		x = {32'd0, bbs_x};
		ks = '0;
		for (int i = 0; i < SQUARINGS; i++) begin
			x = (x * x) % m;
			ks = {ks[BYTE_W-2:0], x[0]};
		end
		bbs_x = x[CFG_W-1:0];
		return ks;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch @%0t: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk) begin
		logic [BYTE_W-1:0] want;
		if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODULUS: bbs_modulus = cfg_data;
				REG_SEED:    bbs_seed    = cfg_data;
				default:     ;
			endcase
		end
		if (s_tvalid && s_tready) begin
			want = s_tdata ^ next_keystream(s_tuser);
			out_byte_q = {out_byte_q, (pin_en ? pin_byte : want)};
		end
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (out_byte_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word out_byte=%02h", m_tdata));
			end else begin
				want = out_byte_q.pop_front();
				if (m_tdata !== want)
					report_mismatch($sformatf("out_byte got %02h want %02h", m_tdata, want));
			end
		end
	end

	// receiver: random stalls, one long hold-off to back up the input
	initial begin
		bit held;
		held = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic put_word(input logic [BYTE_W-1:0] d, input logic st,
	                        input logic pinned, input logic [BYTE_W-1:0] pinned_out);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= st;
		pin_en   <= pinned;
		pin_byte <= pinned_out;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (out_byte_q.size() != 0) @(posedge clk);
	endtask

	task automatic load_regs(input logic [CFG_W-1:0] modulus, input logic [CFG_W-1:0] seed);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_MODULUS;
		cfg_data  <= modulus;
		@(posedge clk);
		cfg_index <= REG_SEED;
		cfg_data  <= seed;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int unsigned       sent;
		int unsigned       phase;
		int unsigned       left;
		int unsigned       len;
		logic [CFG_W-1:0]  modulus;
		logic [CFG_W-1:0]  seed;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_MODULUS;
		cfg_data  <= '0;
		pin_en    <= 1'b0;
		pin_byte  <= '0;

		dir_rows = '{
			// with reset values the keystream is zero, before and at a message start
			'{ROW_WORD, 32'd0, 32'd0, 8'h00, 1'b0, 1'b1, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'hFF, 1'b0, 1'b1, 8'hFF},
			'{ROW_WORD, 32'd0, 32'd0, 8'hA5, 1'b1, 1'b1, 8'hA5},
			// zero modulus acts as one
			'{ROW_REGS, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'h3C, 1'b1, 1'b1, 8'h3C},
			'{ROW_WORD, 32'd0, 32'd0, 8'hC3, 1'b0, 1'b1, 8'hC3},
			'{ROW_REGS, 32'h0000_0001, 32'h1234_5678, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'h5A, 1'b1, 1'b1, 8'h5A},
			'{ROW_REGS, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'h00, 1'b1, 1'b0, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'hFF, 1'b0, 1'b0, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'h81, 1'b0, 1'b0, 8'h00},
			'{ROW_REGS, 32'd209, 32'd3, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'h00, 1'b1, 1'b0, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'h7E, 1'b0, 1'b0, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'hFF, 1'b0, 1'b0, 8'h00},
			// seed above modulus
			'{ROW_REGS, 32'd209, 32'd1000, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'h00, 1'b1, 1'b0, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'h11, 1'b1, 1'b0, 8'h00},
			// zero seed stays zero
			'{ROW_REGS, 32'hFFFF_FFFB, 32'd0, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'hEE, 1'b1, 1'b1, 8'hEE},
			'{ROW_REGS, 32'hC5A3_9E27, 32'hFFFF_FFFE, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'h42, 1'b1, 1'b0, 8'h00},
			'{ROW_WORD, 32'd0, 32'd0, 8'h24, 1'b0, 1'b0, 8'h00}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sent = 0;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_REGS) begin
				load_regs(dir_rows[r].modulus, dir_rows[r].seed);
			end else begin
				put_word(dir_rows[r].data, dir_rows[r].start,
				         dir_rows[r].pinned, dir_rows[r].pinned_out);
				sent++;
			end
		end

		phase = 0;
		while (sent < ITEMS) begin
			case ($urandom_range(9))
				0:       modulus = '0;
				1:       modulus = 32'd1;
				2:       modulus = '1;
				3:       modulus = $urandom_range(2, 255);
				default: modulus = $urandom;
			endcase
			seed = ($urandom_range(7) == 0) ? '0 : $urandom;
			load_regs(modulus, seed);
			calm = (phase == 4);
			left = $urandom_range(40, 100);
			while (left > 0 && sent < ITEMS) begin
				if ($urandom_range(9) == 0) begin
					// stray word with a random start flag
					put_word(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
					         1'b0, '0);
					left--;
					sent++;
				end else begin
					len = $urandom_range(1, 24);
					for (int k = 0; k < len && left > 0; k++) begin
						put_word(BYTE_W'($urandom_range(255)), k == 0, 1'b0, '0);
						left--;
						sent++;
					end
				end
			end
			calm = 0;
			phase++;
		end

		wait_drained();
		repeat (DRAIN) @(posedge clk);
		if (out_byte_q.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", out_byte_q.size()));

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
